### sv/linear_probe_hash_table_top_defines.svh
// Assertion macros used by the checker file
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define LPHT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication: antecedent at one edge, consequent at the next
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/lpht_pkg.sv
`default_nettype none
package lpht_pkg;

	localparam int MAX_CAPACITY = 1024;
	localparam int KEY_BYTES    = 8;
	localparam int IDX_W        = 10;
	localparam int CNT_W        = 11;
	localparam int ADDR_W       = 11;
	localparam int DEPTH        = 2 * MAX_CAPACITY;

	localparam logic [1:0] ST_INSERTED  = 2'd0;
	localparam logic [1:0] ST_FOUND     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	typedef struct packed {
		logic        used;
		logic [15:0] value;
		logic [63:0] key;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// Keep bytes up to the first zero byte
	function automatic logic [63:0] trim_key(input logic [63:0] raw);
		logic [63:0] k;
		logic        live;
		k    = '0;
		live = 1'b1;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (raw[8*i +: 8] == 8'd0)
				live = 1'b0;
			if (live)
				k[8*i +: 8] = raw[8*i +: 8];
		end
		return k;
	endfunction

	function automatic logic [CNT_W-1:0] byte_sum(input logic [63:0] k);
		logic [CNT_W-1:0] s;
		s = '0;
		for (int i = 0; i < 8; i++)
			s = s + {3'd0, k[8*i +: 8]};
		return s;
	endfunction

endpackage
`default_nettype wire

### sv/lpht_mem.sv
`default_nettype none
module lpht_mem (
	input  logic              clk,
	input  lpht_pkg::mem_req_t req,
	output lpht_pkg::entry_t  rdata
);

	lpht_pkg::entry_t mem_q [lpht_pkg::DEPTH];
	lpht_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we)
			mem_q[req.waddr] <= req.wdata;
		rdata_q <= mem_q[req.raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### sv/lpht_mod.sv
`default_nettype none
// Restoring remainder, one quotient bit per cycle
module lpht_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lpht_pkg::CNT_W-1:0] dividend,
	input  logic [lpht_pkg::CNT_W-1:0] divisor,
	output logic                       done,
	output logic [lpht_pkg::CNT_W-1:0] rem
);

	localparam int W  = lpht_pkg::CNT_W;
	localparam int SW = $clog2(W);

	logic [W-1:0]   rem_q;
	logic [W-1:0]   div_q;
	logic [SW-1:0]  step_q;
	logic           run_q;
	logic           done_q;
	logic [2*W-1:0] shifted;
	logic           fits;

	assign shifted = {{W{1'b0}}, div_q} << step_q;
	assign fits    = {{W{1'b0}}, rem_q} >= shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= SW'(W - 1);
			end else if (run_q) begin
				if (step_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			div_q <= divisor;
		end else if (run_q && fits) begin
			rem_q <= rem_q - shifted[W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

### sv/linear_probe_hash_table_top.sv
// Key/value table with open addressing and linear probing in one slot memory
// of two banks. The hash is the byte sum of the key modulo the current
// capacity, taken by an 11-step remainder unit. After reset and after every
// write of initial_capacity the block clears all 2048 slots, one per cycle,
// and takes no item while it clears. An operation then takes the entry and
// the hash, then per slot probed one read and one compare, then posts the
// result; a lookup probes up to capacity+1 slots, and an insert into a full
// table skips the hash and the probes. An insert that pushes the load above
// three quarters also doubles the table if twice the capacity is at most
// 1024: it clears the new bank's 2*capacity slots, then reads each old slot
// and, for each used one, hashes its key and probes the new bank. The
// remainder unit and the memory's one read per cycle set the pace.
`default_nettype none
module linear_probe_hash_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // key[63:0], value[79:64]
	input  logic        s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // found_value[15:0], slot_index[25:16],
	                              // item_count[36:26], capacity_now[47:37]
	output logic [1:0]  m_tuser,  // status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = lpht_pkg::IDX_W;
	localparam int CW = lpht_pkg::CNT_W;
	localparam int AW = lpht_pkg::ADDR_W;
	localparam logic [CW-1:0] CAP_MAX = CW'(lpht_pkg::MAX_CAPACITY);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_HASH  = 4'd2;
	localparam logic [3:0] S_PRD   = 4'd3;
	localparam logic [3:0] S_PEV   = 4'd4;
	localparam logic [3:0] S_RCLR  = 4'd5;
	localparam logic [3:0] S_RRD   = 4'd6;
	localparam logic [3:0] S_REV   = 4'd7;
	localparam logic [3:0] S_RHASH = 4'd8;
	localparam logic [3:0] S_RPRD  = 4'd9;
	localparam logic [3:0] S_RPEV  = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	logic [3:0]    state_q;
	logic [AW-1:0] clr_q;
	logic          bank_q;
	logic [CW-1:0] cap_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] init_cap_q;
	logic          act_q;
	logic [63:0]   key_q;
	logic [15:0]   val_q;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] n_q;
	logic [IW-1:0] slot_q;
	logic [IW-1:0] moved_q;
	logic [1:0]    res_q;
	logic [15:0]   found_q;
	logic [CW-1:0] scan_q;
	logic [63:0]   rkey_q;
	logic [15:0]   rval_q;
	logic          m_valid_q;
	logic [47:0]   m_data_q;
	logic [1:0]    m_user_q;

	lpht_pkg::mem_req_t mreq;
	lpht_pkg::entry_t   rd;

	logic          mod_start;
	logic [CW-1:0] mod_dividend;
	logic [CW-1:0] mod_divisor;
	logic          mod_done;
	logic [CW-1:0] mod_rem;

	logic          cfg_wr;
	logic [CW-1:0] cfg_val;
	logic          in_acc;
	logic [63:0]   in_key;
	logic [CW-1:0] ncap;
	logic [CW-1:0] lim;
	logic [IW-1:0] idx_nxt;
	logic [CW-1:0] count_inc;
	logic          grow;
	logic          scan_last;

	lpht_mem u_mem (
		.clk   (clk),
		.req   (mreq),
		.rdata (rd)
	);

	lpht_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dividend),
		.divisor  (mod_divisor),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && !paddr[2];
	assign prdata   = paddr[2] ? 32'd0 : {{(32-CW){1'b0}}, init_cap_q};
	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign in_key   = lpht_pkg::trim_key(s_tdata[63:0]);
	assign ncap     = {cap_q[CW-2:0], 1'b0};

	always_comb begin
		cfg_val = pwdata[CW-1:0];
		if (cfg_val == '0)
			cfg_val = CW'(1);
		else if (cfg_val > CAP_MAX)
			cfg_val = CAP_MAX;
	end

	// Rehash probes wrap at the doubled size
	assign lim       = (state_q == S_RPEV) ? ncap : cap_q;
	assign idx_nxt   = ({1'b0, idx_q} + 1'b1 == lim) ? '0 : idx_q + 1'b1;
	assign count_inc = count_q + 1'b1;
	assign grow      = ({count_inc, 2'b00} > ({2'b00, cap_q} + {1'b0, cap_q, 1'b0}))
	                   && (ncap <= CAP_MAX) && !cap_q[CW-1];
	assign scan_last = (scan_q + 1'b1 == cap_q);

	always_comb begin
		mod_start    = 1'b0;
		mod_dividend = lpht_pkg::byte_sum(in_key);
		mod_divisor  = cap_q;
		if (state_q == S_IDLE) begin
			mod_start = in_acc && !(s_tuser == lpht_pkg::ACT_INSERT && count_q >= cap_q);
		end else if (state_q == S_REV) begin
			mod_start    = rd.used;
			mod_dividend = lpht_pkg::byte_sum(rd.key);
			mod_divisor  = ncap;
		end
	end

	always_comb begin
		mreq       = '0;
		mreq.raddr = {bank_q, idx_q};
		case (state_q)
			S_CLR: begin
				mreq.we    = 1'b1;
				mreq.waddr = clr_q;
			end
			S_PEV: begin
				mreq.waddr = {bank_q, idx_q};
				mreq.wdata = '{used: 1'b1, value: val_q, key: key_q};
				mreq.we    = (act_q == lpht_pkg::ACT_INSERT) && !rd.used;
			end
			S_RCLR: begin
				mreq.we    = 1'b1;
				mreq.waddr = {!bank_q, clr_q[IW-1:0]};
			end
			S_RRD: mreq.raddr = {bank_q, scan_q[IW-1:0]};
			S_RPRD: mreq.raddr = {!bank_q, idx_q};
			S_RPEV: begin
				mreq.waddr = {!bank_q, idx_q};
				mreq.wdata = '{used: 1'b1, value: rval_q, key: rkey_q};
				mreq.we    = !rd.used;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_q      <= '0;
			bank_q     <= 1'b0;
			cap_q      <= CW'(16);
			count_q    <= '0;
			init_cap_q <= CW'(16);
			m_valid_q  <= 1'b0;
		end else if (cfg_wr) begin
			init_cap_q <= cfg_val;
			cap_q      <= cfg_val;
			bank_q     <= 1'b0;
			count_q    <= '0;
			clr_q      <= '0;
			state_q    <= S_CLR;
		end else begin
			if (m_valid_q && m_tready && state_q != S_DONE)
				m_valid_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(lpht_pkg::DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_acc) begin
						if (mod_start) begin
							state_q <= S_HASH;
						end else begin
							res_q   <= lpht_pkg::ST_FULL;
							found_q <= '0;
							slot_q  <= '0;
							state_q <= S_DONE;
						end
					end
				end
				S_HASH: if (mod_done) state_q <= S_PRD;
				S_PRD: state_q <= S_PEV;
				S_PEV: begin
					if (act_q == lpht_pkg::ACT_INSERT) begin
						if (rd.used) begin
							state_q <= S_PRD;
						end else begin
							count_q <= count_inc;
							res_q   <= lpht_pkg::ST_INSERTED;
							found_q <= '0;
							slot_q  <= idx_q;
							clr_q   <= '0;
							state_q <= grow ? S_RCLR : S_DONE;
						end
					end else if (rd.key == key_q) begin
						res_q   <= lpht_pkg::ST_FOUND;
						found_q <= rd.value;
						slot_q  <= idx_q;
						state_q <= S_DONE;
					end else if (n_q == cap_q) begin
						res_q   <= lpht_pkg::ST_NOT_FOUND;
						found_q <= '0;
						slot_q  <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_PRD;
					end
				end
				S_RCLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q + 1'b1 == ncap)
						state_q <= S_RRD;
				end
				S_RRD: state_q <= S_REV;
				S_REV: begin
					if (rd.used) begin
						state_q <= S_RHASH;
					end else if (scan_last) begin
						bank_q  <= !bank_q;
						cap_q   <= ncap;
						slot_q  <= moved_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_RRD;
					end
				end
				S_RHASH: if (mod_done) state_q <= S_RPRD;
				S_RPRD: state_q <= S_RPEV;
				S_RPEV: begin
					if (rd.used) begin
						state_q <= S_RPRD;
					end else if (scan_last) begin
						bank_q  <= !bank_q;
						cap_q   <= ncap;
						slot_q  <= (scan_q[IW-1:0] == slot_q) ? idx_q : moved_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_RRD;
					end
				end
				S_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q <= s_tuser;
			key_q <= in_key;
			val_q <= s_tdata[79:64];
			n_q   <= '0;
		end
		if ((state_q == S_HASH || state_q == S_RHASH) && mod_done)
			idx_q <= mod_rem[IW-1:0];
		// Lookups step past every slot, inserts only past used ones
		if ((state_q == S_PEV && (rd.used || act_q == lpht_pkg::ACT_LOOKUP))
				|| (state_q == S_RPEV && rd.used))
			idx_q <= idx_nxt;
		if (state_q == S_PEV)
			n_q <= n_q + 1'b1;
		if (state_q == S_PEV && grow)
			scan_q <= '0;
		if (state_q == S_REV) begin
			rkey_q <= rd.key;
			rval_q <= rd.value;
			if (!rd.used)
				scan_q <= scan_q + 1'b1;
		end
		if (state_q == S_RPEV && !rd.used) begin
			scan_q <= scan_q + 1'b1;
			if (scan_q[IW-1:0] == slot_q)
				moved_q <= idx_q;
		end
		if (state_q == S_DONE && (!m_valid_q || m_tready)) begin
			m_user_q <= res_q;
			m_data_q <= {cap_q, count_q, slot_q, found_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule
`default_nettype wire

### sv/lpht_checker.sv
`default_nettype none
`include "linear_probe_hash_table_top_defines.svh"
module lpht_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser
);

	`LPHT_ASSERT_NEXT(a_in_busy, s_tvalid && s_tready, !s_tready, "input taken while busy")
	`LPHT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
	`LPHT_ASSERT(a_cap_range, !m_tvalid || (m_tdata[47:37] != 11'd0 && m_tdata[47:37] <= 11'd1024), "capacity out of range")
	`LPHT_ASSERT(a_count_cap, !m_tvalid || (m_tdata[36:26] <= m_tdata[47:37]), "item count above capacity")
	`LPHT_ASSERT(a_full_count, !(m_tvalid && m_tuser == lpht_pkg::ST_FULL) || (m_tdata[36:26] == m_tdata[47:37] && m_tdata[25:0] == 26'd0), "full reported with room left")

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (.*);
`default_nettype wire

### bench/linear_probe_hash_table_top_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_table_top_tb;

	localparam int STALL_LIMIT = 600000;

	typedef struct {
		logic        act;
		logic [63:0] key;
		logic [15:0] val;
	} op_t;

	typedef struct {
		logic [1:0]  st;
		logic [15:0] fv;
		logic [9:0]  slot;
		logic [10:0] cnt;
		logic [10:0] cap;
	} res_t;

	typedef struct {
		op_t  op;
		bit   typed;
		res_t res;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;   // key[63:0], value[79:64]
	logic        s_tuser;   // action
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // found_value[15:0], slot_index[25:16],
	                        // item_count[36:26], capacity_now[47:37]
	logic [1:0]  m_tuser;   // status
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	linear_probe_hash_table_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// table shadow
	logic [63:0] shadow_key[lpht_pkg::DEPTH];
	logic [15:0] shadow_val[lpht_pkg::DEPTH];
	bit          shadow_used[lpht_pkg::DEPTH];
	int          shadow_bank;
	int          shadow_cap;
	int          shadow_cnt;
	int          start_cap;

	res_t        pending_results[$];
	logic [63:0] stored_keys[$];
	row_t        dir_rows[$];
	int          mismatches;
	int          idle_cycles;
	bit          no_gaps;
	int          ready_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] strip_key(input logic [63:0] raw);
		logic [63:0] k;
		k = '0;
		for (int i = 0; i < lpht_pkg::KEY_BYTES; i++) begin
			if (raw[8*i +: 8] == 8'd0)
				break;
			k[8*i +: 8] = raw[8*i +: 8];
		end
		return k;
	endfunction

	function automatic int byte_hash(input logic [63:0] k, input int c);
		int s;
		s = 0;
		for (int i = 0; i < 8; i++)
			s += k[8*i +: 8];
		return s % c;
	endfunction

	function automatic void wipe_bank(input int b);
		for (int i = 0; i < lpht_pkg::MAX_CAPACITY; i++) begin
			shadow_key[b*lpht_pkg::MAX_CAPACITY + i]  = '0;
			shadow_val[b*lpht_pkg::MAX_CAPACITY + i]  = '0;
			shadow_used[b*lpht_pkg::MAX_CAPACITY + i] = 1'b0;
		end
	endfunction

	function automatic int store_entry(input int b, input int c, input logic [63:0] k,
			input logic [15:0] v);
		int idx;
		idx = byte_hash(k, c);
		for (int n = 0; n < c; n++) begin
			if (!shadow_used[b*lpht_pkg::MAX_CAPACITY + idx])
				break;
			idx = (idx + 1) % c;
		end
		shadow_key[b*lpht_pkg::MAX_CAPACITY + idx]  = k;
		shadow_val[b*lpht_pkg::MAX_CAPACITY + idx]  = v;
		shadow_used[b*lpht_pkg::MAX_CAPACITY + idx] = 1'b1;
		return idx;
	endfunction

	function automatic void restart_table();
		wipe_bank(0);
		wipe_bank(1);
		shadow_bank = 0;
		shadow_cnt  = 0;
		shadow_cap  = start_cap;
	endfunction

	function automatic res_t table_step(input op_t op);
		res_t        r;
		logic [63:0] k;
		int          base, idx, nb, ncap, moved, ni;
		k    = strip_key(op.key);
		base = shadow_bank * lpht_pkg::MAX_CAPACITY;
		r.fv   = '0;
		r.slot = '0;
		if (op.act == lpht_pkg::ACT_INSERT) begin
			if (shadow_cnt >= shadow_cap) begin
				r.st = lpht_pkg::ST_FULL;
			end else begin
				idx = store_entry(shadow_bank, shadow_cap, k, op.val);
				shadow_cnt++;
				r.st = lpht_pkg::ST_INSERTED;
				// grow: rehash in slot order into the other bank
				if (4*shadow_cnt > 3*shadow_cap && 2*shadow_cap <= lpht_pkg::MAX_CAPACITY) begin
					nb    = shadow_bank ^ 1;
					ncap  = 2 * shadow_cap;
					moved = 0;
					wipe_bank(nb);
					for (int i = 0; i < shadow_cap; i++) begin
						if (shadow_used[base + i]) begin
							ni = store_entry(nb, ncap, shadow_key[base + i], shadow_val[base + i]);
							if (i == idx)
								moved = ni;
						end
					end
					idx         = moved;
					shadow_bank = nb;
					shadow_cap  = ncap;
				end
				r.slot = idx[9:0];
			end
		end else begin
			idx  = byte_hash(k, shadow_cap);
			r.st = lpht_pkg::ST_NOT_FOUND;
			for (int n = 0; n <= shadow_cap; n++) begin
				if (shadow_key[base + idx] == k) begin
					r.st   = lpht_pkg::ST_FOUND;
					r.fv   = shadow_val[base + idx];
					r.slot = idx[9:0];
					break;
				end
				idx = (idx + 1) % shadow_cap;
			end
		end
		r.cnt = shadow_cnt[10:0];
		r.cap = shadow_cap[10:0];
		return r;
	endfunction

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
		mismatches++;
	endtask

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// response side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			ready_hold <= 0;
		end else if (no_gaps) begin
			m_tready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			m_tready   <= ($urandom_range(0, 2) != 0);
			ready_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50)
				: $urandom_range(0, 3);
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser != want.st)
					report_mismatch("status", m_tuser, want.st);
				if (m_tdata[15:0] != want.fv)
					report_mismatch("found_value", m_tdata[15:0], want.fv);
				if (m_tdata[25:16] != want.slot)
					report_mismatch("slot_index", m_tdata[25:16], want.slot);
				if (m_tdata[36:26] != want.cnt)
					report_mismatch("item_count", m_tdata[36:26], want.cnt);
				if (m_tdata[47:37] != want.cap)
					report_mismatch("capacity_now", m_tdata[47:37], want.cap);
			end
		end
	end

	// hang detection
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_op(input op_t op, input bit typed, input res_t typed_res);
		int   gap;
		res_t r;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op.act;
		s_tdata  <= {op.val, op.key};
		do @(posedge clk); while (!s_tready);
		r = table_step(op);
		pending_results.push_back(typed ? typed_res : r);
		if (op.act == lpht_pkg::ACT_INSERT)
			stored_keys.push_back(op.key);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [31:0] v);
		drain();
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= '0;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		start_cap = (v[10:0] == 0) ? 1 : (v[10:0] > lpht_pkg::MAX_CAPACITY)
			? lpht_pkg::MAX_CAPACITY : v[10:0];
		restart_table();
		stored_keys.delete();
		@(posedge clk);
		if (prdata != 32'(start_cap))
			report_mismatch("initial_capacity", prdata, start_cap);
	endtask

	function automatic logic [63:0] rand_key();
		logic [63:0] k;
		int          len;
		case ($urandom_range(0, 2))
			0: k = {$urandom(), $urandom()};
			default: begin
				k   = {$urandom(), $urandom()};
				len = $urandom_range(0, 8);
				for (int i = 0; i < 8; i++) begin
					if (i < len && k[8*i +: 8] == 8'd0)
						k[8*i +: 8] = 8'h5a;
					if (i == len)
						k[8*i +: 8] = 8'd0;
				end
				// drop the tail after the terminator sometimes
				if ($urandom_range(0, 1) == 0 && len < 8)
					for (int i = len; i < 8; i++)
						k[8*i +: 8] = 8'd0;
			end
		endcase
		return k;
	endfunction

	task automatic random_phase(input int n, input int insert_pct);
		op_t  op;
		res_t none;
		none = '{default: '0};
		for (int i = 0; i < n; i++) begin
			op.act = ($urandom_range(0, 99) < insert_pct) ? lpht_pkg::ACT_INSERT
				: lpht_pkg::ACT_LOOKUP;
			op.val = 16'($urandom());
			if (stored_keys.size() != 0 && $urandom_range(0, 99) < 60)
				op.key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
			else
				op.key = rand_key();
			send_op(op, 1'b0, none);
		end
	endtask

	task automatic add_row(input logic act, input logic [63:0] key, input logic [15:0] val,
			input bit typed, input logic [1:0] st, input logic [15:0] fv, input int slot,
			input int cnt, input int cap);
		row_t row;
		row.op    = '{act: act, key: key, val: val};
		row.typed = typed;
		row.res   = '{st: st, fv: fv, slot: slot[9:0], cnt: cnt[10:0], cap: cap[10:0]};
		dir_rows.push_back(row);
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		mismatches  = 0;
		no_gaps     = 1'b0;
		start_cap   = 16;
		restart_table();

		// empty key matches a free slot, full-width keys, trimming, duplicates
		add_row(lpht_pkg::ACT_LOOKUP, 64'h0, 16'h0, 1, lpht_pkg::ST_FOUND, 16'h0, 0, 0, 16);
		add_row(lpht_pkg::ACT_LOOKUP, '1, 16'h0, 1, lpht_pkg::ST_NOT_FOUND, 16'h0, 0, 0, 16);
		add_row(lpht_pkg::ACT_INSERT, 64'h0, 16'hffff, 1, lpht_pkg::ST_INSERTED, 16'h0,
			0, 1, 16);
		add_row(lpht_pkg::ACT_INSERT, '1, 16'h0, 1, lpht_pkg::ST_INSERTED, 16'h0, 8, 2, 16);
		add_row(lpht_pkg::ACT_INSERT, 64'hab00_0000_0000_0041, 16'h1234, 1,
			lpht_pkg::ST_INSERTED, 16'h0, 1, 3, 16);
		add_row(lpht_pkg::ACT_LOOKUP, 64'h41, 16'h0, 1, lpht_pkg::ST_FOUND, 16'h1234, 1, 3, 16);
		add_row(lpht_pkg::ACT_LOOKUP, 64'h7700_0000_0000_0041, 16'hffff, 1,
			lpht_pkg::ST_FOUND, 16'h1234, 1, 3, 16);
		add_row(lpht_pkg::ACT_INSERT, 64'h41, 16'h5555, 1, lpht_pkg::ST_INSERTED, 16'h0,
			2, 4, 16);
		add_row(lpht_pkg::ACT_LOOKUP, 64'h41, 16'h0, 1, lpht_pkg::ST_FOUND, 16'h1234, 1, 4, 16);
		add_row(lpht_pkg::ACT_LOOKUP, 64'h0, 16'h0, 1, lpht_pkg::ST_FOUND, 16'hffff, 0, 4, 16);
		add_row(lpht_pkg::ACT_LOOKUP, 64'h8080_8080_8080_8080, 16'h0, 0, '0, '0, 0, 0, 0);
		// push the load past three quarters to force a doubling
		for (int i = 1; i <= 10; i++)
			add_row(lpht_pkg::ACT_INSERT, 64'h0102_0304_0506_0700 + i * 64'h0101,
				16'(i) * 16'h1111, 0, '0, '0, 0, 0, 0);
		add_row(lpht_pkg::ACT_LOOKUP, '1, 16'h0, 0, '0, '0, 0, 0, 0);
		add_row(lpht_pkg::ACT_LOOKUP, 64'h41, 16'h0, 0, '0, '0, 0, 0, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_op(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].res);
		random_phase(180, 55);

		write_capacity(32'd0);
		random_phase(150, 50);

		write_capacity(32'd2047);
		random_phase(20, 50);

		// no room to double: fill to the cap and hit full
		write_capacity(32'd513);
		random_phase(600, 92);

		no_gaps = 1'b1;
		write_capacity(32'd3);
		random_phase(100, 50);
		no_gaps = 1'b0;

		write_capacity(32'd64);
		random_phase(150, 55);

		write_capacity(32'd1);
		random_phase(100, 50);

		drain();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
